// ===== hw/rtl/lpht_pkg.sv =====
package lpht_pkg;

    localparam int TABLE_SLOTS_DEF   = 1024;
    localparam int MAX_KEY_BYTES_DEF = 8;

    localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_PRIME_LOW = 9'h1B3;   // prime = 2^40 + 0x1B3
    localparam int          FNV_PRIME_SHIFT = 40;

    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_PUT = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  key_len;
        logic [63:0] value;
    } slot_entry_t;

    typedef struct packed {
        logic       tag_we;
        logic       entry_we;
        logic [1:0] tag;
    } slot_wr_t;

endpackage

// ===== hw/rtl/lpht_fnv.sv =====
module lpht_fnv
    import lpht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    input  logic [3:0]  len,
    output logic        done,
    output logic [63:0] hash
);

    logic        busy_reg, busy_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] sh_reg, sh_next;
    logic [63:0] h_mul;

    // multiply by the FNV prime as a shift plus a narrow product
    assign h_mul = (h_reg << FNV_PRIME_SHIFT) + (h_reg * {55'd0, FNV_PRIME_LOW});

    assign done = busy_reg && (cnt_reg == 4'd0);
    assign hash = h_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        h_next    = h_reg;
        sh_next   = sh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = len;
            h_next    = FNV_OFFSET;
            sh_next   = key;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                // fold one byte per cycle
                h_next   = h_mul ^ {56'd0, sh_reg[7:0]};
                sh_next  = sh_reg >> 8;
                cnt_next = cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg  <= h_next;
        sh_reg <= sh_next;
    end

endmodule

// ===== hw/rtl/lpht_slot_store.sv =====
module lpht_slot_store
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int IDX_W       = $clog2(TABLE_SLOTS)
)
(
    input  logic               clk,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [1:0]         rd_tag,
    output slot_entry_t        rd_entry,
    input  slot_wr_t           wr,
    input  logic [IDX_W-1:0]   wr_addr,
    input  slot_entry_t        wr_entry
);

    logic [1:0]  tag_mem [TABLE_SLOTS];
    slot_entry_t ent_mem [TABLE_SLOTS];
    logic [1:0]  rd_tag_reg;
    slot_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr.tag_we)
        begin
            tag_mem[wr_addr] <= wr.tag;
        end
        if (wr.entry_we)
        begin
            ent_mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_tag_reg   <= tag_mem[rd_addr];
            rd_entry_reg <= ent_mem[rd_addr];
        end
    end

    assign rd_tag   = rd_tag_reg;
    assign rd_entry = rd_entry_reg;

endmodule

// ===== hw/rtl/linear_probe_hash_table_core.sv =====
// Open-addressing hash table with linear probing and 64-bit FNV-1 hashing.
// Each request (get, put or delete) gives exactly one response carrying a
// status and, for a get that hits, the stored value. After reset the block
// sweeps the tag memory, one slot per cycle, before it takes its first
// request. A request is then accepted, hashed byte by byte in the serial
// hash unit (whose last step issues the first slot read), probed one slot
// after another (the tag/entry memory has a single read port with a
// registered output) and its response is posted. One request is in flight
// at a time; a new request is taken while the previous response still waits
// on out_stall.
module linear_probe_hash_table_core
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS   = TABLE_SLOTS_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [63:0] key_bytes,
    input  logic [3:0]  key_length,
    input  logic [63:0] put_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] got_value
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [1:0]       op_reg, op_next;
    logic [63:0]      key_reg, key_next;
    logic [3:0]       len_reg, len_next;
    logic [63:0]      val_reg, val_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] probe_reg, probe_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [63:0]      res_value_reg, res_value_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic [63:0]      out_value_reg, out_value_next;

    logic             in_accept;
    logic [3:0]       len_sat;
    logic [63:0]      key_masked;
    logic             hash_start;
    logic             hash_done;
    logic [63:0]      hash;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [1:0]       rd_tag;
    slot_entry_t      rd_entry;
    slot_wr_t         wr;
    logic [IDX_W-1:0] wr_addr;
    slot_entry_t      wr_entry;
    logic             match;
    logic             last_probe;
    logic             out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign got_value = out_value_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // saturate the length and drop bytes past it
    assign len_sat = (key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_length;

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            key_masked[8*b +: 8] = (4'(b) < len_sat) ? key_bytes[8*b +: 8] : 8'd0;
        end
    end

    assign hash_start = in_accept && (opcode == OP_GET || opcode == OP_PUT
                                      || opcode == OP_DEL);

    lpht_fnv u_fnv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_masked),
        .len   (len_sat),
        .done  (hash_done),
        .hash  (hash)
    );

    lpht_slot_store #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_store
    (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_tag   (rd_tag),
        .rd_entry (rd_entry),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    // A slot matches only while live; key and length of other slots are ignored.
    assign match = (rd_tag == TAG_LIVE) && (rd_entry.key_len == len_reg)
                   && (rd_entry.key == key_reg);
    assign last_probe = (probe_reg == CNT_W'(TABLE_SLOTS - 1));

    assign wr_entry.key     = key_reg;
    assign wr_entry.key_len = len_reg;
    assign wr_entry.value   = val_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr.tag_we       = 1'b0;
        wr.entry_we     = 1'b0;
        wr.tag          = TAG_LIVE;
        wr_addr         = idx_reg;

        // drop the response once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // sweep every tag to empty
                wr.tag_we = 1'b1;
                wr.tag    = TAG_EMPTY;
                wr_addr   = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next         = opcode;
                    key_next        = key_masked;
                    len_next        = len_sat;
                    val_next        = put_value;
                    probe_next      = '0;
                    res_status_next = ST_MISS;
                    res_value_next  = 64'd0;
                    // unused opcode answers at once with a miss
                    state_next      = hash_start ? S_HASH : S_DONE;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = hash[IDX_W-1:0];
                    idx_next   = hash[IDX_W-1:0];
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (op_reg == OP_PUT)
                begin
                    if (match)
                    begin
                        wr.entry_we     = 1'b1;
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end
                    else if (rd_tag != TAG_LIVE)
                    begin
                        // claim the first free slot, empty or tombstone
                        wr.tag_we   = 1'b1;
                        wr.tag      = TAG_LIVE;
                        wr.entry_we = 1'b1;
                        if (rd_tag == TAG_EMPTY)
                        begin
                            used_next = used_reg + 1'b1;
                        end
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_reg + 1'b1;
                        idx_next   = idx_reg + 1'b1;
                        probe_next = probe_reg + 1'b1;
                    end
                end
                else
                begin
                    if (match)
                    begin
                        res_status_next = ST_OK;
                        if (op_reg == OP_GET)
                        begin
                            res_value_next = rd_entry.value;
                        end
                        else
                        begin
                            wr.tag_we = 1'b1;
                            wr.tag    = TAG_TOMB;
                        end
                        state_next = S_DONE;
                    end
                    else if (rd_tag == TAG_EMPTY || last_probe)
                    begin
                        res_status_next = ST_MISS;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // skip tombstones and foreign keys
                        rd_en      = 1'b1;
                        rd_addr    = idx_reg + 1'b1;
                        idx_next   = idx_reg + 1'b1;
                        probe_next = probe_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                // hold the result until the output register frees
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            probe_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            probe_reg     <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("response posted outside the done state");

    a_tag_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        wr.tag_we |-> (state_reg == S_PROBE || state_reg == S_CLEAR))
        else $error("tag write outside probe or clear");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_SLOTS))
        else $error("used slot count exceeds the table");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> probe_reg < CNT_W'(TABLE_SLOTS))
        else $error("probe ran past the table");

endmodule
